>>> design/fah_pkg.sv
package fah_pkg;

  localparam int ADDR_W        = 15;
  localparam int SIZE_W        = 16;
  localparam int LEN_W         = 16;
  localparam int EN_W          = 18;
  localparam int STAT_W        = 3;
  localparam int MAX_HOLES_DEF = 64;

  localparam logic [ADDR_W-1:0] LAST_ADDR = 15'd32767;

  localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
  localparam logic [STAT_W-1:0] STAT_NOFIT   = 3'd1;
  localparam logic [STAT_W-1:0] STAT_OVERLAP = 3'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE   = 3'd3;
  localparam logic [STAT_W-1:0] STAT_ZERO    = 3'd4;
  localparam logic [STAT_W-1:0] STAT_FULL    = 3'd5;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SHRINK,
    OP_DEL,
    OP_MERGE,
    OP_SETEND,
    OP_SETSTART,
    OP_INS
  } op_kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } fah_state_t;

  typedef struct packed {
    logic              vld;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] fin;
  } hole_t;

  typedef struct packed {
    op_kind_t          kind;
    logic              policy;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
    logic [EN_W-1:0]   en;
  } op_t;

  typedef struct packed {
    logic              vld;
    logic              found;
    logic [LEN_W-1:0]  best_len;
    logic [ADDR_W-1:0] best_end;
    logic              overlap;
    logic              pfound;
    logic              left;
    logic              right;
  } scan_t;

endpackage

>>> design/fah_if.sv
interface fah_req_if;
  import fah_pkg::*;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [ADDR_W-1:0] address;
  logic [SIZE_W-1:0] size;
  modport source (output valid, mode, address, size, input ready);
  modport sink   (input valid, mode, address, size, output ready);
endinterface

interface fah_rsp_if;
  import fah_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ADDR_W-1:0] granted_address;
  modport source (output valid, status, granted_address, input ready);
  modport sink   (input valid, status, granted_address, output ready);
endinterface

interface fah_cfg_if;
  logic valid;
  logic ready;
  logic fit_policy;
  modport source (output valid, fit_policy, input ready);
  modport sink   (input valid, fit_policy, output ready);
endinterface

>>> design/fah_cell.sv
module fah_cell #(
  parameter int MAX_HOLES = 64,
  parameter int IDX       = 0,
  localparam int CW       = $clog2(MAX_HOLES + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  fah_pkg::op_t    op,
  input  logic [CW-1:0]   op_idx,
  input  fah_pkg::hole_t  prev_hole,
  input  fah_pkg::hole_t  next_hole,
  output fah_pkg::hole_t  hole,
  input  fah_pkg::scan_t  scan_in,
  input  logic [CW-1:0]   best_idx_in,
  input  logic [CW-1:0]   p_idx_in,
  output fah_pkg::scan_t  scan_out,
  output logic [CW-1:0]   best_idx_out,
  output logic [CW-1:0]   p_idx_out
);
  import fah_pkg::*;

  localparam logic [CW-1:0] MY_IDX  = CW'(IDX);
  localparam logic [CW-1:0] MY_NEXT = CW'(IDX + 1);

  hole_t           hole_r, hole_nxt;
  scan_t           scan_r, scan_nxt;
  logic [CW-1:0]   best_r, best_nxt;
  logic [CW-1:0]   p_r, p_nxt;
  logic [LEN_W-1:0] len;
  logic [EN_W-1:0]  s18, e18, st18;
  logic             ovl, fits, take;

  always_comb begin
    hole_nxt = hole_r;
    case (op.kind)
      OP_SHRINK: begin
        if (op_idx == MY_IDX) hole_nxt.fin = hole_r.fin - op.size[ADDR_W-1:0];
      end
      OP_DEL: begin
        if (MY_IDX >= op_idx) hole_nxt = next_hole;
      end
      OP_MERGE: begin
        if (MY_NEXT == op_idx) hole_nxt.fin = next_hole.fin;
        else if (MY_IDX >= op_idx) hole_nxt = next_hole;
      end
      OP_SETEND: begin
        if (MY_NEXT == op_idx) hole_nxt.fin = op.en[ADDR_W-1:0];
      end
      OP_SETSTART: begin
        if (MY_IDX == op_idx) hole_nxt.start = op.addr;
      end
      OP_INS: begin
        if (MY_IDX == op_idx) begin
          hole_nxt.vld   = 1'b1;
          hole_nxt.start = op.addr;
          hole_nxt.fin   = op.en[ADDR_W-1:0];
        end else if (MY_IDX > op_idx) begin
          hole_nxt = prev_hole;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    len  = {1'b0, hole_r.fin} - {1'b0, hole_r.start} + LEN_W'(1);
    s18  = EN_W'(hole_r.start);
    e18  = EN_W'(hole_r.fin);
    st18 = EN_W'(op.addr);
    ovl  = ($signed(st18) <= $signed(s18) && $signed(s18) <= $signed(op.en)) ||
           ($signed(st18) <= $signed(e18) && $signed(e18) <= $signed(op.en)) ||
           ($signed(s18) <= $signed(st18) && $signed(st18) <= $signed(e18)) ||
           ($signed(s18) <= $signed(op.en) && $signed(op.en) <= $signed(e18));
    fits = len >= op.size;
    take = fits && (op.policy ? (!scan_in.found || len < scan_in.best_len)
                              : !scan_in.found);
    scan_nxt = scan_in;
    best_nxt = best_idx_in;
    p_nxt    = p_idx_in;
    if (scan_in.vld && hole_r.vld) begin
      if (ovl) scan_nxt.overlap = 1'b1;
      if (take) begin
        scan_nxt.found    = 1'b1;
        scan_nxt.best_len = len;
        scan_nxt.best_end = hole_r.fin;
        best_nxt          = MY_IDX;
      end
      if (hole_r.start < op.addr) begin
        scan_nxt.left = ({1'b0, hole_r.fin} + LEN_W'(1)) == {1'b0, op.addr};
      end else if (!scan_in.pfound) begin
        scan_nxt.pfound = 1'b1;
        scan_nxt.right  = {2'b0, hole_r.start} == (op.en[EN_W-2:0] + (EN_W-1)'(1));
        p_nxt           = MY_IDX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r       <= '0;
      best_r       <= '0;
      p_r          <= '0;
      hole_r.vld   <= (IDX == 0);
      hole_r.start <= '0;
      hole_r.fin   <= (IDX == 0) ? LAST_ADDR : '0;
    end else begin
      hole_r <= hole_nxt;
      scan_r <= scan_nxt;
      best_r <= best_nxt;
      p_r    <= p_nxt;
    end
  end

  assign hole         = hole_r;
  assign scan_out     = scan_r;
  assign best_idx_out = best_r;
  assign p_idx_out    = p_r;

endmodule

>>> design/free_hole_allocator.sv
// A request is taken only while idle; the scan token then walks the hole-cell
// chain one cell per cycle, and all cells are updated together once the
// result register is free, so the next request waits until that update.
// A new request is taken while an earlier result still waits for transfer.
// Reset: one hole covering the whole space, first-fit policy, channels idle.
module free_hole_allocator #(
  parameter int MAX_HOLES = fah_pkg::MAX_HOLES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  fah_req_if.sink      in_ch,
  fah_rsp_if.source    out_ch,
  fah_cfg_if.sink      cfg_ch
);
  import fah_pkg::*;

  localparam int CW = $clog2(MAX_HOLES + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_HOLES);

  fah_state_t        state_r, state_nxt;
  logic              policy_r;
  logic              mode_r;
  logic [ADDR_W-1:0] addr_r;
  logic [SIZE_W-1:0] size_r;
  logic              launch_r;
  logic [CW-1:0]     count_r;
  scan_t             res_r;
  logic [CW-1:0]     res_best_r, res_p_r;
  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [ADDR_W-1:0] out_grant_r;

  logic [EN_W-1:0]   en;
  op_t               op;
  op_kind_t          dec_kind;
  logic [CW-1:0]     dec_idx, p_sel;
  logic [STAT_W-1:0] dec_stat;
  logic [ADDR_W-1:0] dec_grant;
  logic              in_xfer, apply;
  scan_t             launch_scan;

  hole_t             holes [MAX_HOLES];
  scan_t             scans [MAX_HOLES];
  logic [CW-1:0]     bidx  [MAX_HOLES];
  logic [CW-1:0]     pidx  [MAX_HOLES];
  logic [MAX_HOLES-1:0] vld_vec, scan_vec;

  assign in_xfer = in_ch.valid && in_ch.ready;
  assign apply   = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign en      = EN_W'(addr_r) + EN_W'(size_r) - EN_W'(1);
  assign p_sel   = res_r.pfound ? res_p_r : count_r;

  always_comb begin
    launch_scan     = '0;
    launch_scan.vld = launch_r;
    op.kind   = apply ? dec_kind : OP_NONE;
    op.policy = policy_r;
    op.addr   = addr_r;
    op.size   = size_r;
    op.en     = en;
  end

  always_comb begin
    dec_kind  = OP_NONE;
    dec_idx   = '0;
    dec_stat  = STAT_OK;
    dec_grant = '0;
    if (mode_r) begin
      if (size_r == '0) begin
        dec_stat = STAT_ZERO;
      end else if (!res_r.found) begin
        dec_stat = STAT_NOFIT;
      end else begin
        dec_grant = res_r.best_end - size_r[ADDR_W-1:0] + ADDR_W'(1);
        dec_idx   = res_best_r;
        dec_kind  = (res_r.best_len == size_r) ? OP_DEL : OP_SHRINK;
      end
    end else begin
      dec_idx = p_sel;
      if (res_r.overlap) dec_stat = STAT_OVERLAP;
      else if ($signed(en) > $signed(EN_W'(LAST_ADDR))) dec_stat = STAT_RANGE;
      else if (size_r == '0) dec_stat = STAT_ZERO;
      else if (res_r.left && res_r.right) dec_kind = OP_MERGE;
      else if (res_r.left) dec_kind = OP_SETEND;
      else if (res_r.right) dec_kind = OP_SETSTART;
      else if (count_r == FULL_CNT) dec_stat = STAT_FULL;
      else dec_kind = OP_INS;
    end
  end

  genvar g;
  generate
    for (g = 0; g < MAX_HOLES; g++) begin : g_cell
      hole_t         prev_h, next_h;
      scan_t         s_in;
      logic [CW-1:0] b_in, p_in;
      if (g == 0) begin : g_first
        assign prev_h = '0;
        assign s_in   = launch_scan;
        assign b_in   = '0;
        assign p_in   = '0;
      end else begin : g_rest
        assign prev_h = holes[g-1];
        assign s_in   = scans[g-1];
        assign b_in   = bidx[g-1];
        assign p_in   = pidx[g-1];
      end
      if (g == MAX_HOLES - 1) begin : g_last
        assign next_h = '0;
      end else begin : g_mid
        assign next_h = holes[g+1];
      end
      fah_cell #(.MAX_HOLES(MAX_HOLES), .IDX(g)) u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .op_idx       (dec_idx),
        .prev_hole    (prev_h),
        .next_hole    (next_h),
        .hole         (holes[g]),
        .scan_in      (s_in),
        .best_idx_in  (b_in),
        .p_idx_in     (p_in),
        .scan_out     (scans[g]),
        .best_idx_out (bidx[g]),
        .p_idx_out    (pidx[g])
      );
      assign vld_vec[g]  = holes[g].vld;
      assign scan_vec[g] = scans[g].vld;
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_xfer) state_nxt = S_SCAN;
      S_SCAN: if (scans[MAX_HOLES-1].vld) state_nxt = S_DONE;
      S_DONE: if (apply) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready            = (state_r == S_IDLE);
    cfg_ch.ready           = 1'b1;
    out_ch.valid           = out_valid_r;
    out_ch.status          = out_status_r;
    out_ch.granted_address = out_grant_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      policy_r    <= 1'b0;
      launch_r    <= 1'b0;
      count_r     <= CW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= in_xfer;
      if (cfg_ch.valid) policy_r <= cfg_ch.fit_policy;
      if (apply) begin
        out_valid_r <= 1'b1;
        if (dec_kind == OP_DEL || dec_kind == OP_MERGE) count_r <= count_r - CW'(1);
        else if (dec_kind == OP_INS) count_r <= count_r + CW'(1);
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode_r <= in_ch.mode;
      addr_r <= in_ch.address;
      size_r <= in_ch.size;
    end
    if (state_r == S_SCAN && scans[MAX_HOLES-1].vld) begin
      res_r      <= scans[MAX_HOLES-1];
      res_best_r <= bidx[MAX_HOLES-1];
      res_p_r    <= pidx[MAX_HOLES-1];
    end
    if (apply) begin
      out_status_r <= dec_stat;
      out_grant_r  <= dec_grant;
    end
  end

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld_vec) == int'(count_r))
    else $error("hole count disagrees with valid cells");

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(scan_vec))
    else $error("more than one scan token in the chain");

  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != STAT_OK |-> out_grant_r == '0)
    else $error("nonzero grant on failed request");

  a_idle_no_token: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !launch_r && scan_vec == '0)
    else $error("scan token live while idle");

endmodule
